### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the keyed string probe hash.
// Each macro samples on clk_i; KSPH_ASSERT is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled in reset
`define KSPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property check that also holds during reset
`define KSPH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/ksph_pkg.sv
// Package for the keyed string probe hash: item codes, payload structs,
// seeds and S-box geometry. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksph_pkg;

  // S-box geometry
  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned SBOX_AW    = $clog2(SBOX_DEPTH);

  // Hash seeds
  localparam logic [31:0] POS_SEED  = 32'h1F35_1F35;
  localparam logic [31:0] STEP_SEED = 32'h8F1B_BCDC;

  // Smallest usable table size
  localparam logic [4:0] MIN_TABLE_LOG2 = 5'd3;

  // Item codes; the fourth code is ignored
  typedef enum logic [1:0] {
    MODE_ABSORB = 2'd0,
    MODE_FINISH = 2'd1,
    MODE_LOAD   = 2'd2
  } mode_e;

  // Absorb sequencer phases
  typedef enum logic [0:0] {
    PH_ISSUE = 1'b0,
    PH_MIX   = 1'b1
  } phase_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  key_byte;
    logic [7:0]  sbox_index;
    logic [31:0] sbox_word;
  } item_t;

  typedef struct packed {
    logic [31:0] probe_start;
    logic [31:0] probe_step;
    logic [30:0] first_slot;
  } res_t;

  // S-box port request from the hash core
  typedef struct packed {
    logic               we;
    logic [SBOX_AW-1:0] waddr;
    logic [31:0]        wdata;
    logic               re;
    logic [SBOX_AW-1:0] raddr;
  } sbox_req_t;

endpackage

`default_nettype wire

### rtl/ksph_in_if.sv
// Input channel of the keyed string probe hash: valid/ready plus item fields.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface ksph_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  key_byte;
  logic [7:0]  sbox_index;
  logic [31:0] sbox_word;

  modport source (output valid, output mode, output key_byte, output sbox_index,
                  output sbox_word, input ready);
  modport sink   (input valid, input mode, input key_byte, input sbox_index,
                  input sbox_word, output ready);
endinterface

`default_nettype wire

### rtl/ksph_out_if.sv
// Result channel of the keyed string probe hash: valid/ready plus result fields.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface ksph_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] probe_start;
  logic [31:0] probe_step;
  logic [30:0] first_slot;

  modport source (output valid, output probe_start, output probe_step,
                  output first_slot, input ready);
  modport sink   (input valid, input probe_start, input probe_step,
                  input first_slot, output ready);
endinterface

`default_nettype wire

### rtl/ksph_sbox.sv
// 256 x 32 S-box RAM: one write port, one read port with registered data.
// Depends on ksph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksph_sbox (
  input  logic                  clk_i,
  input  ksph_pkg::sbox_req_t   req_i,
  output logic [31:0]           rd_data_o
);
  import ksph_pkg::*;

  logic [31:0] mem [SBOX_DEPTH];
  logic [31:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/ksph_core.sv
// Hash core: absorb sequencer, pos/step words, byte count and finalization.
// Depends on ksph_pkg and assert_macros.svh; drives the S-box RAM ports.
`timescale 1ns / 1ps
`default_nettype none

module ksph_core #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_v_i,
  input  ksph_pkg::item_t     item_i,
  input  logic                out_free_i,
  input  logic [4:0]          table_log2_i,
  input  logic [31:0]         rd_data_i,
  output ksph_pkg::sbox_req_t sbox_req_o,
  output logic                done_o,
  output logic                emit_o,
  output ksph_pkg::res_t      res_o
);
  import ksph_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_KEY_BYTES + 1);

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        pend_q, pend_d;
  logic [31:0] pend_cx_q, pend_cx_d;

  logic [31:0] cx;
  logic [31:0] step_eff;
  logic [31:0] pos_new;
  logic        is_finish;

  logic [4:0]  lg;
  logic [30:0] mask;
  logic [31:0] st_raw;
  logic [31:0] ps;
  logic [31:0] slot_sum;

  // sign-extended key character
  assign cx = {{24{item_i.key_byte[7]}}, item_i.key_byte};

  // step update left pending from the last absorbed byte, its S-box word now in rd_data_i
  assign step_eff = pend_q ? ({step_q[26:0], step_q[31:27]} + (rd_data_i ^ pend_cx_q))
                           : step_q;

  assign pos_new = {pos_q[28:0], pos_q[31:29]} + (rd_data_i ^ cx);

  assign is_finish = (item_i.mode == MODE_FINISH) ||
                     ((item_i.mode == MODE_ABSORB) && (item_i.key_byte == 8'd0));

  // finalization; the OR of the low step bit is folded into the slot sum
  assign lg       = (table_log2_i < MIN_TABLE_LOG2) ? MIN_TABLE_LOG2 : table_log2_i;
  assign mask     = 31'h7FFF_FFFF >> (5'd31 - lg);
  assign st_raw   = step_q + {16'd0, step_q[31:16]};
  assign ps       = pos_q ^ {16'd0, pos_q[31:16]};
  assign slot_sum = ps + step_q + {16'd0, step_q[31:16]} +
                    {31'd0, ~(step_q[0] ^ step_q[16])};

  assign res_o.probe_start = ps;
  assign res_o.probe_step  = {st_raw[31:1], 1'b1};
  assign res_o.first_slot  = slot_sum[30:0] & mask;

  // sequencer: next state, state words and S-box requests
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    step_d     = step_eff;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pend_cx_d  = pend_cx_q;
    done_o     = 1'b0;
    emit_o     = 1'b0;
    sbox_req_o = '0;
    sbox_req_o.waddr = item_i.sbox_index;
    sbox_req_o.wdata = item_i.sbox_word;

    if (item_v_i) begin
      if (is_finish) begin
        // wait out a pending step update and a busy result register, then emit and reseed
        if (!pend_q && out_free_i) begin
          emit_o = 1'b1;
          done_o = 1'b1;
          pos_d  = POS_SEED;
          step_d = STEP_SEED;
          cnt_d  = '0;
        end
      end else begin
        unique case (item_i.mode)
          MODE_ABSORB: begin
            if (cnt_q >= CNT_W'(MAX_KEY_BYTES)) begin
              done_o = 1'b1;
            end else begin
              unique case (phase_q)
                PH_ISSUE: begin
                  sbox_req_o.re    = 1'b1;
                  sbox_req_o.raddr = item_i.key_byte + step_eff[7:0];
                  phase_d          = PH_MIX;
                end
                PH_MIX: begin
                  pos_d            = pos_new;
                  sbox_req_o.re    = 1'b1;
                  sbox_req_o.raddr = item_i.key_byte + pos_new[7:0];
                  pend_d           = 1'b1;
                  pend_cx_d        = cx;
                  cnt_d            = cnt_q + CNT_W'(1);
                  done_o           = 1'b1;
                  phase_d          = PH_ISSUE;
                end
                default: phase_d = PH_ISSUE;
              endcase
            end
          end
          MODE_LOAD: begin
            sbox_req_o.we = 1'b1;
            done_o        = 1'b1;
          end
          default: done_o = 1'b1;
        endcase
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ISSUE;
      pos_q   <= POS_SEED;
      step_q  <= STEP_SEED;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // payload of the pending step update
  always_ff @(posedge clk_i) begin
    pend_cx_q <= pend_cx_d;
  end

  `include "assert_macros.svh"

  `KSPH_ASSERT(a_mix_has_item, (phase_q == PH_MIX) |-> item_v_i, "mix phase without item")
  `KSPH_ASSERT(a_pend_one_cycle, pend_q |=> !pend_q, "step update pending too long")
  `KSPH_ASSERT(a_pend_after_mix, pend_q |-> (phase_q == PH_ISSUE), "pending step in mix phase")
  `KSPH_ASSERT(a_emit_reseeds, emit_o |=> ((cnt_q == '0) && (pos_q == POS_SEED)), "no reseed")
  `KSPH_ASSERT_ALWAYS(a_one_ram_op, !(sbox_req_o.we && sbox_req_o.re), "S-box read and write")

endmodule

`default_nettype wire

### rtl/keyed_string_probe_hash.sv
// Keyed string probe hash. Each key byte passes an issue and a mix phase: its
// two S-box reads depend on each other (step then new pos) and go through the
// one registered read port of the 256-word S-box RAM. A finish right after a
// byte waits while the last step word settles, and every finish waits for a
// free output register. Results leave through an output register, so other
// items are still taken while a result waits for its transfer.
// Top level; depends on ksph_pkg, ksph_in_if, ksph_out_if, ksph_sbox, ksph_core.
`timescale 1ns / 1ps
`default_nettype none

module keyed_string_probe_hash #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ksph_in_if.sink           in_i,
  ksph_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [4:0]        cfg_wdata_i
);
  import ksph_pkg::*;

  logic        item_v_q;
  item_t       item_q;
  logic        out_v_q;
  res_t        res_q;
  logic [4:0]  table_log2_q;

  logic        in_xfer;
  logic        out_free;
  logic        core_done;
  logic        core_emit;
  res_t        core_res;
  sbox_req_t   sbox_req;
  logic [31:0] rd_data;

  assign in_i.ready = !item_v_q || core_done;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_v_q || out_o.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (in_xfer) begin
      item_v_q <= 1'b1;
    end else if (core_done) begin
      item_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.mode       <= in_i.mode;
      item_q.key_byte   <= in_i.key_byte;
      item_q.sbox_index <= in_i.sbox_index;
      item_q.sbox_word  <= in_i.sbox_word;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (core_emit) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_emit) begin
      res_q <= core_res;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.probe_start = res_q.probe_start;
  assign out_o.probe_step  = res_q.probe_step;
  assign out_o.first_slot  = res_q.first_slot;

  // table size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_log2_q <= MIN_TABLE_LOG2;
    end else if (cfg_we_i) begin
      table_log2_q <= cfg_wdata_i;
    end
  end

  ksph_sbox u_sbox (
    .clk_i     (clk_i),
    .req_i     (sbox_req),
    .rd_data_o (rd_data)
  );

  ksph_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_v_i     (item_v_q),
    .item_i       (item_q),
    .out_free_i   (out_free),
    .table_log2_i (table_log2_q),
    .rd_data_i    (rd_data),
    .sbox_req_o   (sbox_req),
    .done_o       (core_done),
    .emit_o       (core_emit),
    .res_o        (core_res)
  );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for keyed_string_probe_hash: a queue-fed driver,
// a result monitor and an in-bench hash predictor compared field by field.
// Depends on ksph_pkg, ksph_in_if, ksph_out_if and the keyed_string_probe_hash RTL.
`timescale 1ns / 1ps

module tb;
  import ksph_pkg::*;

  localparam int unsigned MAX_KEY   = 256;
  localparam logic [1:0]  MODE_NOP  = 2'd3;   // fourth code, ignored by the block
  localparam int          LONG_HOLD = 400;    // receiver back-pressure stretch
  localparam int          SETTLE    = 8;      // cycles after the last result
  localparam int          DRAIN_MAX = 20000;
  localparam int          LIMIT     = 400000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  ksph_in_if  in_ch ();
  ksph_out_if out_ch ();

  keyed_string_probe_hash #(
    .MAX_KEY_BYTES(MAX_KEY)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Stimulus and expectation stores
  item_t pending_items[$];
  res_t  expected_probes[$];
  item_t next_item;

  // Predictor state
  logic [31:0] sbox_img [0:SBOX_DEPTH-1];
  logic [31:0] pos_acc;
  logic [31:0] step_acc;
  int unsigned taken_bytes;
  logic [4:0]  table_log2;

  // Handshake bookkeeping
  int unsigned n_offered;
  int unsigned n_accepted;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned pattern_left;
  int unsigned stall_sel;
  int unsigned long_hold_req;
  int unsigned long_hold_done;
  int unsigned cycles;
  int unsigned err_count;

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < 40)
      $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Predictor: advance the hash for one transfer and queue any result
  task automatic absorb_item(input item_t it);
    logic [31:0] cext;
    logic [31:0] st;
    logic [31:0] ps;
    logic [31:0] slot;
    logic [7:0]  ri;
    logic [4:0]  lg;
    logic [30:0] mask;
    res_t        r;
    cext = {{24{it.key_byte[7]}}, it.key_byte};
    if (it.mode == MODE_LOAD) begin
      sbox_img[it.sbox_index] = it.sbox_word;
    end else if (it.mode == MODE_FINISH ||
                 (it.mode == MODE_ABSORB && it.key_byte == 8'h00)) begin
      lg   = (table_log2 < MIN_TABLE_LOG2) ? MIN_TABLE_LOG2 : table_log2;
      mask = (lg >= 5'd31) ? 31'h7FFF_FFFF : ((31'd1 << lg) - 31'd1);
      st   = step_acc + (step_acc >> 16);
      st[0] = 1'b1;
      ps   = pos_acc ^ (pos_acc >> 16);
      slot = ps + st;
      r.probe_start = ps;
      r.probe_step  = st;
      r.first_slot  = slot[30:0] & mask;
      expected_probes.push_back(r);
      pos_acc     = POS_SEED;
      step_acc    = STEP_SEED;
      taken_bytes = 0;
    end else if (it.mode == MODE_ABSORB) begin
      // bytes past the key limit are dropped
      if (taken_bytes < MAX_KEY) begin
        ri       = it.key_byte + step_acc[7:0];
        pos_acc  = {pos_acc[28:0], pos_acc[31:29]} + (sbox_img[ri] ^ cext);
        ri       = it.key_byte + pos_acc[7:0];
        step_acc = {step_acc[26:0], step_acc[31:27]} + (sbox_img[ri] ^ cext);
        taken_bytes++;
      end
    end
  endtask

  // Input monitor, result checker and cycle count
  always @(posedge clk) begin
    item_t seen;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_probes.size() == 0) begin
          report_mismatch("unexpected result, probe_start", out_ch.probe_start, '0);
        end else begin
          if (out_ch.probe_start !== expected_probes[0].probe_start)
            report_mismatch("probe_start", out_ch.probe_start,
                            expected_probes[0].probe_start);
          if (out_ch.probe_step !== expected_probes[0].probe_step)
            report_mismatch("probe_step", out_ch.probe_step,
                            expected_probes[0].probe_step);
          if (out_ch.first_slot !== expected_probes[0].first_slot)
            report_mismatch("first_slot", {1'b0, out_ch.first_slot},
                            {1'b0, expected_probes[0].first_slot});
          void'(expected_probes.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.mode       = in_ch.mode;
        seen.key_byte   = in_ch.key_byte;
        seen.sbox_index = in_ch.sbox_index;
        seen.sbox_word  = in_ch.sbox_word;
        absorb_item(seen);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
      burst_left  <= 0;
    end else if (in_ch.valid && n_offered != n_accepted) begin
      // hold the item until it is taken
    end else if (gap_left != 0) begin
      in_ch.valid <= 1'b0;
      gap_left    <= gap_left - 1;
    end else if (pending_items.size() != 0) begin
      next_item = pending_items.pop_front();
      in_ch.mode       <= next_item.mode;
      in_ch.key_byte   <= next_item.key_byte;
      in_ch.sbox_index <= next_item.sbox_index;
      in_ch.sbox_word  <= next_item.sbox_word;
      in_ch.valid      <= 1'b1;
      n_offered        <= n_offered + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: stall pattern of its own, plus long holds on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      pattern_left <= 0;
      stall_sel    <= 0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (long_hold_req != long_hold_done) begin
      out_ch.ready   <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= long_hold_done + 1;
    end else begin
      if (pattern_left == 0) begin
        stall_sel    <= $urandom_range(0, 2);
        pattern_left <= $urandom_range(16, 96);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (stall_sel)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_item(input logic [1:0] mode, input logic [7:0] kb,
                           input logic [7:0] idx, input logic [31:0] wd);
    item_t it;
    it.mode       = mode;
    it.key_byte   = kb;
    it.sbox_index = idx;
    it.sbox_word  = wd;
    pending_items.push_back(it);
  endtask

  // One key of nonzero bytes, sometimes with loads or ignored codes mixed in,
  // closed by a finish or a zero byte; returns the number of counted items
  task automatic queue_key(input int unsigned len, output int unsigned n);
    n = 0;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 19))
        0:       begin
          push_item(MODE_LOAD, 8'($urandom), 8'($urandom), $urandom);
          n++;
        end
        1:       push_item(MODE_NOP, 8'($urandom), 8'($urandom), $urandom);
        default: ;
      endcase
      push_item(MODE_ABSORB, 8'($urandom_range(1, 255)), 8'($urandom), $urandom);
      n++;
    end
    if ($urandom_range(0, 1))
      push_item(MODE_FINISH, 8'($urandom), 8'($urandom), $urandom);
    else
      push_item(MODE_ABSORB, 8'h00, 8'($urandom), $urandom);
    n++;
  endtask

  task automatic queue_random_mix(input int unsigned n_items);
    int unsigned done;
    int unsigned n;
    done = 0;
    while (done < n_items) begin
      case ($urandom_range(0, 9))
        0: begin
          push_item(MODE_LOAD, 8'($urandom), 8'($urandom), $urandom);
          done++;
        end
        1: push_item(MODE_NOP, 8'($urandom), 8'($urandom), $urandom);
        2: begin
          queue_key($urandom_range(11, 40), n);
          done += n;
        end
        default: begin
          queue_key($urandom_range(0, 10), n);
          done += n;
        end
      endcase
    end
  endtask

  // Wait for every queued item to be taken and every result to arrive
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    while ((pending_items.size() != 0 || in_ch.valid || expected_probes.size() != 0)
           && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_table_log2(input logic [4:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    table_log2 = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    logic [4:0] settings [8];
    int unsigned n;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = '0;
    in_ch.key_byte   = '0;
    in_ch.sbox_index = '0;
    in_ch.sbox_word  = '0;
    out_ch.ready   = 1'b0;
    n_offered      = 0;
    n_accepted     = 0;
    long_hold_req  = 0;
    long_hold_done = 0;
    cycles         = 0;
    err_count      = 0;
    pos_acc        = POS_SEED;
    step_acc       = STEP_SEED;
    taken_bytes    = 0;
    table_log2     = MIN_TABLE_LOG2;
    for (int i = 0; i < SBOX_DEPTH; i++) sbox_img[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the whole S-box so no key byte reads an unwritten entry
    for (int i = 0; i < SBOX_DEPTH; i++)
      push_item(MODE_LOAD, 8'($urandom), i[7:0], $urandom);

    // Directed: empty keys, sign extremes, zero-byte finish, ignored code,
    // a load in the middle of a key, field extremes
    push_item(MODE_FINISH, 8'h00, 8'h00, 32'h0000_0000);
    push_item(MODE_ABSORB, 8'h00, 8'hFF, 32'hFFFF_FFFF);
    push_item(MODE_ABSORB, 8'h01, 8'h00, 32'h0);
    push_item(MODE_ABSORB, 8'h7F, 8'h00, 32'h0);
    push_item(MODE_ABSORB, 8'h80, 8'h00, 32'h0);
    push_item(MODE_ABSORB, 8'hFF, 8'h00, 32'h0);
    push_item(MODE_FINISH, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_item(MODE_ABSORB, 8'h80, 8'h00, 32'h0);
    push_item(MODE_NOP,    8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_item(MODE_ABSORB, 8'h00, 8'h00, 32'h0);
    push_item(MODE_ABSORB, 8'h41, 8'h00, 32'h0);
    push_item(MODE_LOAD,   8'h00, 8'h00, 32'h0000_0000);
    push_item(MODE_LOAD,   8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_item(MODE_ABSORB, 8'h42, 8'h00, 32'h0);
    push_item(MODE_FINISH, 8'h00, 8'h00, 32'h0);
    push_item(MODE_NOP,    8'h00, 8'h00, 32'h0);
    push_item(MODE_FINISH, 8'h5A, 8'hA5, 32'h5A5A_A5A5);
    wait_drained();

    // Random phases over several table sizes, extremes and clamped values
    settings[0] = 5'd31;
    settings[1] = 5'd0;
    settings[2] = 5'd30;
    settings[3] = 5'd2;
    settings[4] = 5'd1;
    settings[5] = 5'd3;
    settings[6] = 5'd17;
    settings[7] = 5'($urandom_range(3, 31));
    for (int p = 0; p < 8; p++) begin
      set_table_log2(settings[p]);
      // a key longer than the limit, closed by a finish or a zero byte
      if (p == 3) queue_key($urandom_range(260, 280), n);
      queue_random_mix(55);
      // receiver holds off while the sender keeps offering
      if (p == 1 || p == 5) long_hold_req = long_hold_req + 1;
      wait_drained();
    end

    if (pending_items.size() != 0 || expected_probes.size() != 0)
      report_mismatch("items left at end", pending_items.size(), expected_probes.size());
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ksph_pkg.sv
rtl/ksph_in_if.sv
rtl/ksph_out_if.sv
rtl/ksph_sbox.sv
rtl/ksph_core.sv
rtl/keyed_string_probe_hash.sv
tb/sv/tb.sv
